FILE: hdl/gbm_pkg.sv
// Package for greedy_box_merge_max: constants, box record, controller/datapath link types.
// Depends on nothing.
`timescale 1ns / 1ps
package gbm_pkg;
  localparam int MaxBoxesDef  = 64;
  localparam int CoordBitsDef = 14;
  localparam int ConfBits     = 16;
  localparam int ThreshBits   = 8;
  localparam logic [ThreshBits-1:0] ThreshReset = 8'd128;

  typedef struct packed {
    logic load;       // write input beat into box store
    logic sort_cap;   // capture box being inserted
    logic sort_step;  // write hole: shifted entry or inserted box
    logic walk_cap;   // capture box being merged
    logic kept_cmp;   // evaluate overlap against kept entry
    logic kept_wr;    // write captured box into kept table at kidx
    logic emit_cap;   // capture output beat
  } gbm_cmd_t;

  typedef struct packed {
    logic meet;       // captured box meets current kept entry
    logic higher;     // captured box has higher confidence
  } gbm_stat_t;
endpackage

FILE: hdl/gbm_ram.sv
// Generic single write, single read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module gbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/gbm_datapath.sv
// Datapath: box store sorted in place by width, kept table, overlap test pipeline.
// Depends on gbm_pkg and gbm_ram.
`timescale 1ns / 1ps
module gbm_datapath #(
  parameter int MaxBoxes  = gbm_pkg::MaxBoxesDef,
  parameter int CoordBits = gbm_pkg::CoordBitsDef,
  localparam int AW = $clog2(MaxBoxes),
  localparam int BW = 4 * CoordBits + gbm_pkg::ConfBits
) (
  input  logic                        clk,
  input  gbm_pkg::gbm_cmd_t           cmd,
  input  logic [AW-1:0]               load_addr,
  input  logic [BW-1:0]               load_box,
  input  logic [AW-1:0]               box_raddr,
  input  logic [AW-1:0]               sort_j,    // current hole
  output logic                        sort_move, // entry at j-1 wider than insert
  input  logic [AW-1:0]               kidx,
  input  logic [gbm_pkg::ThreshBits-1:0] thresh,
  output gbm_pkg::gbm_stat_t          stat,
  output logic [BW-1:0]               out_box
);
  import gbm_pkg::*;
  localparam int CB = CoordBits;
  localparam int EB = CB + 1;
  localparam int AB = 2 * CB;

  logic [BW-1:0] box_rd, kept_rd;
  logic [BW-1:0] ins;
  logic [BW-1:0] cur;
  logic          box_we;
  logic [AW-1:0] box_waddr;
  logic [BW-1:0] box_wdata;

  assign sort_move = (sort_j != '0) && (box_rd[3*CB-1:2*CB] > ins[3*CB-1:2*CB]);
  assign box_we    = cmd.load || cmd.sort_step;
  assign box_waddr = cmd.load ? load_addr : sort_j;
  assign box_wdata = cmd.load ? load_box : (sort_move ? box_rd : ins);

  gbm_ram #(.Width(BW), .Depth(MaxBoxes)) u_box (
    .clk, .we(box_we), .waddr(box_waddr), .wdata(box_wdata),
    .raddr(box_raddr), .rdata(box_rd));

  gbm_ram #(.Width(BW), .Depth(MaxBoxes)) u_kept (
    .clk, .we(cmd.kept_wr), .waddr(kidx), .wdata(cur),
    .raddr(kidx), .rdata(kept_rd));

  always_ff @(posedge clk) begin
    if (cmd.sort_cap) ins <= box_rd;
    if (cmd.walk_cap) cur <= box_rd;
    if (cmd.emit_cap) out_box <= kept_rd;
  end

  function automatic logic [EB-1:0] span(input logic [CB-1:0] a0, input logic [CB-1:0] al,
                                         input logic [CB-1:0] b0, input logic [CB-1:0] bl);
    logic [EB-1:0] a1, b1, lo, hi;
    a1 = EB'(a0) + EB'(al);
    b1 = EB'(b0) + EB'(bl);
    lo = (a0 > b0) ? EB'(a0) : EB'(b0);
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : '0;
  endfunction

  // stage 1: spans and areas
  logic [EB-1:0] sx, sy;
  logic [AB-1:0] aa, ab;
  logic [ConfBits-1:0] kc;
  always_ff @(posedge clk) begin
    sx <= span(cur[CB-1:0], cur[4*CB-1:3*CB], kept_rd[CB-1:0], kept_rd[4*CB-1:3*CB]);
    sy <= span(cur[2*CB-1:CB], cur[3*CB-1:2*CB], kept_rd[2*CB-1:CB], kept_rd[3*CB-1:2*CB]);
    aa <= AB'(cur[3*CB-1:2*CB]) * AB'(cur[4*CB-1:3*CB]);
    ab <= AB'(kept_rd[3*CB-1:2*CB]) * AB'(kept_rd[4*CB-1:3*CB]);
    kc <= kept_rd[BW-1:4*CB];
  end
  // stage 2: overlap area, min area
  logic [2*EB-1:0] ov;
  logic [AB-1:0]   amin;
  logic [ConfBits-1:0] kc2;
  always_ff @(posedge clk) begin
    ov   <= (2*EB)'(sx) * (2*EB)'(sy);
    amin <= (aa < ab) ? aa : ab;
    kc2  <= kc;
  end
  // stage 3: compare
  logic [2*EB+7:0] lhs, rhs;
  assign lhs = {ov, 8'd0};
  assign rhs = (2*EB+8)'(amin) * (2*EB+8)'(thresh);
  always_ff @(posedge clk) if (cmd.kept_cmp) begin
    stat.meet   <= lhs > rhs;
    stat.higher <= kc2 < cur[BW-1:4*CB];
  end
endmodule

FILE: hdl/gbm_ctrl.sv
// Controller: load, in-place width sort, merge walk and emit sequencing.
// Depends on gbm_pkg.
`timescale 1ns / 1ps
module gbm_ctrl #(
  parameter int MaxBoxes = gbm_pkg::MaxBoxesDef,
  localparam int AW = $clog2(MaxBoxes),
  localparam int CW = $clog2(MaxBoxes + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  output logic              overflow,
  output gbm_pkg::gbm_cmd_t cmd,
  output logic [AW-1:0]     load_addr,
  output logic [AW-1:0]     box_raddr,
  output logic [AW-1:0]     sort_j,
  input  logic              sort_move,
  output logic [AW-1:0]     kidx,
  input  gbm_pkg::gbm_stat_t stat
);
  import gbm_pkg::*;
  typedef enum logic [12:0] {
    S_LOAD  = 13'b0000000000001,
    S_SRD   = 13'b0000000000010,
    S_SCAP  = 13'b0000000000100,
    S_MRD   = 13'b0000000001000,
    S_MSTEP = 13'b0000000010000,
    S_WRD   = 13'b0000000100000,
    S_WCAP  = 13'b0000001000000,
    S_KRD   = 13'b0000010000000,
    S_KPIPE = 13'b0000100000000,
    S_KDEC  = 13'b0001000000000,
    S_ERD   = 13'b0010000000000,
    S_ECAP  = 13'b0100000000000,
    S_EOUT  = 13'b1000000000000
  } state_t;

  state_t state;
  logic [CW-1:0] nload, nkept, pos, widx, k;
  logic [AW-1:0] j;
  logic [1:0] pcnt;
  logic drop;

  assign load_addr = nload[AW-1:0];
  assign sort_j    = j;
  assign kidx      = k[AW-1:0];
  assign in_ready  = (state == S_LOAD);
  assign overflow  = drop;
  assign out_last  = (k + CW'(1) == nkept);

  logic acc;
  assign acc = in_valid && in_ready;

  always_comb begin
    unique case (state)
      S_SRD:   box_raddr = pos[AW-1:0];
      S_MRD:   box_raddr = (j == '0) ? '0 : j - AW'(1);
      default: box_raddr = widx[AW-1:0];
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_LOAD:  cmd.load = acc && (nload != CW'(MaxBoxes));
      S_SCAP:  cmd.sort_cap = 1'b1;
      S_MSTEP: cmd.sort_step = 1'b1;
      S_WCAP:  cmd.walk_cap = 1'b1;
      S_KPIPE: cmd.kept_cmp = (pcnt == 2'd3);
      S_KDEC:  cmd.kept_wr = (k == nkept) ? (nkept != CW'(MaxBoxes))
                             : (stat.meet && stat.higher);
      S_ECAP:  cmd.emit_cap = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; nload <= '0; nkept <= '0; drop <= 1'b0;
      pos <= '0; widx <= '0; k <= '0; j <= '0; pcnt <= '0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (acc) begin
          if (nload != CW'(MaxBoxes)) nload <= nload + CW'(1);
          else drop <= 1'b1;
          if (in_last) begin
            pos <= '0; widx <= '0; k <= '0; nkept <= '0;
            state <= S_SRD;
          end
        end
        S_SRD: state <= S_SCAP;
        S_SCAP: begin j <= pos[AW-1:0]; state <= S_MRD; end
        S_MRD: state <= S_MSTEP;
        S_MSTEP: begin
          if (sort_move) begin
            j <= j - AW'(1); state <= S_MRD;
          end else if (pos + CW'(1) == nload) state <= S_WRD;
          else begin pos <= pos + CW'(1); state <= S_SRD; end
        end
        S_WRD: state <= S_WCAP;
        S_WCAP: begin k <= '0; state <= (nkept == '0) ? S_KDEC : S_KRD; end
        S_KRD: begin pcnt <= '0; state <= S_KPIPE; end
        S_KPIPE: begin
          pcnt <= pcnt + 2'd1;
          if (pcnt == 2'd3) state <= S_KDEC;
        end
        S_KDEC: begin
          if (k == nkept || stat.meet) begin
            if (k == nkept && nkept != CW'(MaxBoxes)) nkept <= nkept + CW'(1);
            if (widx + CW'(1) == nload) begin
              k <= '0; state <= S_ERD;
            end else begin
              widx <= widx + CW'(1); state <= S_WRD;
            end
          end else begin
            k <= k + CW'(1);
            state <= (k + CW'(1) == nkept) ? S_KDEC : S_KRD;
          end
        end
        S_ERD: state <= S_ECAP;
        S_ECAP: begin out_valid <= 1'b1; state <= S_EOUT; end
        S_EOUT: if (out_ready) begin
          out_valid <= 1'b0;
          if (out_last) begin
            nload <= '0; nkept <= '0; drop <= 1'b0; state <= S_LOAD;
          end else begin
            k <= k + CW'(1); state <= S_ERD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

FILE: hdl/greedy_box_merge_max.sv
// Greedy box merge (NMS, max confidence wins). Boxes load one beat per cycle until tlast.
// The set of stored boxes is then sorted by width in place by insertion, each box moving
// past the wider boxes before it. The merge walk compares each box against the kept
// table in order and appends it if none meets (one shared overlap pipeline and one
// kept-table read port). Kept boxes are then emitted in kept-table order, and emission
// waits on output stalls. Input is not accepted while a set is processed or emitted.
// Top level; depends on gbm_pkg, gbm_ctrl, gbm_datapath.
`timescale 1ns / 1ps
module greedy_box_merge_max #(
  parameter int MaxBoxes  = gbm_pkg::MaxBoxesDef,
  parameter int CoordBits = gbm_pkg::CoordBitsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic [gbm_pkg::ThreshBits-1:0] cfg_wdata,
  input  logic cfg_we,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // x, y, w, h, conf, zero fill
  input  logic [((4*CoordBits+gbm_pkg::ConfBits+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // x, y, w, h, conf, overflow, zero fill
  output logic [((4*CoordBits+gbm_pkg::ConfBits+8)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import gbm_pkg::*;
  localparam int AW = $clog2(MaxBoxes);
  localparam int BW = 4 * CoordBits + ConfBits;
  localparam int OW = ((BW + 8) / 8) * 8;

  logic [ThreshBits-1:0] thresh;
  always_ff @(posedge clk) begin
    if (rst) thresh <= ThreshReset;
    else if (cfg_we) thresh <= cfg_wdata;
  end

  gbm_cmd_t cmd;
  gbm_stat_t stat;
  logic [AW-1:0] load_addr, box_raddr, sort_j, kidx;
  logic sort_move, ovf;
  logic [BW-1:0] out_box;

  gbm_ctrl #(.MaxBoxes(MaxBoxes)) u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_last(s_axis_tlast), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_last(m_axis_tlast),
    .overflow(ovf), .cmd, .load_addr, .box_raddr, .sort_j, .sort_move, .kidx,
    .stat);

  gbm_datapath #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits)) u_dp (
    .clk, .cmd, .load_addr, .load_box(s_axis_tdata[BW-1:0]), .box_raddr, .sort_j,
    .sort_move, .kidx, .thresh, .stat, .out_box);

  assign m_axis_tdata = OW'({ovf, out_box});
endmodule

FILE: hdl/gbm_checker.sv
// Port-level checker for greedy_box_merge_max, bound to the top level.
// Depends on greedy_box_merge_max ports only.
`timescale 1ns / 1ps
module gbm_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open during emit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("beat dropped");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("beat after last");
endmodule

bind greedy_box_merge_max gbm_checker u_chk (.*);

FILE: tb/greedy_box_merge_max_test.sv
// Testbench for greedy_box_merge_max: streams box sets, predicts the kept table by
// stable width sort and greedy min-area overlap merge, checks every output beat.
// Depends on gbm_pkg and the greedy_box_merge_max RTL.
`timescale 1ns / 1ps
module greedy_box_merge_max_test;
  localparam int NBox = gbm_pkg::MaxBoxesDef;

  typedef struct {
    logic [13:0] x, y, w, h;
    logic [15:0] conf;
  } box_t;

  typedef struct {
    box_t b;
    logic last;
  } load_t;

  typedef struct {
    box_t b;
    logic ovf;
    logic last;
  } kept_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [7:0] cfg_wdata = 8'd0;
  logic cfg_we = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic m_axis_tlast;

  load_t pending_boxes[$];
  kept_t kept_expected[$];
  load_t beat_on_bus;
  box_t loaded[NBox];
  int load_cnt = 0;
  logic dropped = 1'b0;
  logic [7:0] thresh = gbm_pkg::ThreshReset;
  int errors = 0;
  int gap_cnt = 0;
  int burst_cnt = 4;
  int stall_cnt = 0;
  int cyc = 0;

  always #5 clk = ~clk;

  greedy_box_merge_max u_top (
    .clk(clk), .rst(rst), .cfg_wdata(cfg_wdata), .cfg_we(cfg_we),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  function automatic longint unsigned span(longint unsigned a0, longint unsigned al,
                                           longint unsigned b0, longint unsigned bl);
    longint unsigned lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic bit boxes_overlap(box_t a, box_t b, logic [7:0] th);
    longint unsigned ov, aa, ab, amin;
    ov = span(a.x, a.h, b.x, b.h) * span(a.y, a.w, b.y, b.w);
    aa = longint'(a.w) * longint'(a.h);
    ab = longint'(b.w) * longint'(b.h);
    amin = (aa < ab) ? aa : ab;
    return (ov << 8) > amin * longint'(th);
  endfunction

  task automatic merge_set();
    int order[NBox];
    box_t kept[NBox];
    int nk, i, j, v;
    box_t b;
    nk = 0;
    for (i = 0; i < load_cnt; i++) begin
      v = i;
      j = i;
      while (j > 0 && loaded[order[j-1]].w > loaded[v].w) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    for (i = 0; i < load_cnt; i++) begin
      b = loaded[order[i]];
      for (j = 0; j < nk; j++) begin
        if (boxes_overlap(b, kept[j], thresh)) begin
          if (kept[j].conf < b.conf) kept[j] = b;
          break;
        end
      end
      if (j == nk) begin
        kept[nk] = b;
        nk++;
      end
    end
    for (i = 0; i < nk; i++)
      kept_expected.insert(kept_expected.size(),
                           kept_t'{b: kept[i], ovf: dropped, last: (i == nk - 1)});
    load_cnt = 0;
    dropped = 1'b0;
  endtask

  task automatic box_accepted(load_t it);
    if (load_cnt < NBox) begin
      loaded[load_cnt] = it.b;
      load_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (it.last) merge_set();
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) box_accepted(beat_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_boxes.size() > 0) begin
          beat_on_bus = pending_boxes.pop_front();
          s_axis_tdata <= {beat_on_bus.b.conf, beat_on_bus.b.h, beat_on_bus.b.w,
                           beat_on_bus.b.y, beat_on_bus.b.x};
          s_axis_tlast <= beat_on_bus.last;
          s_axis_tvalid <= 1'b1;
          if (burst_cnt <= 1) begin
            burst_cnt <= $urandom_range(1, 12);
            gap_cnt <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_cnt <= burst_cnt - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    kept_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (kept_expected.size() == 0) begin
          $display("%0t: unexpected beat act=%h last=%b", $time, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          e = kept_expected.pop_front();
          if (m_axis_tdata[72:0] !== {e.ovf, e.b.conf, e.b.h, e.b.w, e.b.y, e.b.x} ||
              m_axis_tlast !== e.last) begin
            $display("%0t: mismatch exp=%h/%b act=%h/%b", $time,
                     {e.ovf, e.b.conf, e.b.h, e.b.w, e.b.y, e.b.x}, e.last,
                     m_axis_tdata[72:0], m_axis_tlast);
            errors++;
          end
        end
      end
      // stall-free stretch: no new stalls start while cycle counter bit 8 is clear
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (cyc[8] && $urandom_range(0, 3) == 0) begin
        stall_cnt <= $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_box(logic [13:0] x, y, w, h, logic [15:0] c, logic l);
    pending_boxes.insert(pending_boxes.size(),
                         load_t'{b: '{x: x, y: y, w: w, h: h, conf: c}, last: l});
  endtask

  task automatic drain();
    while (pending_boxes.size() > 0 || s_axis_tvalid || kept_expected.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_thresh(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    thresh = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_set(int n);
    logic [13:0] bx, by;
    int k;
    bx = 14'($urandom);
    by = 14'($urandom);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0)
        add_box(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
                16'($urandom), k == n - 1);
      else
        add_box(bx + 14'($urandom_range(0, 40)), by + 14'($urandom_range(0, 40)),
                14'($urandom_range(0, 60)), 14'($urandom_range(0, 60)),
                16'($urandom), k == n - 1);
    end
  endtask

  initial begin
    int p, k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // reset threshold
    add_box(14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff, 16'hffff, 1'b1);
    add_box(0, 0, 0, 0, 0, 1'b1);
    add_box(100, 100, 20, 20, 16'h1000, 1'b0);
    add_box(105, 105, 20, 20, 16'h2000, 1'b0);
    add_box(110, 110, 20, 20, 16'h0800, 1'b0);
    add_box(500, 500, 10, 30, 16'h0100, 1'b0);
    add_box(500, 500, 10, 30, 16'h0100, 1'b0);
    add_box(100, 100, 0, 20, 16'hffff, 1'b1);
    drain();
    write_thresh(8'd0);
    add_box(0, 0, 5, 5, 16'h0001, 1'b0);
    add_box(4, 4, 5, 5, 16'h0002, 1'b0);
    add_box(14'h3ff0, 14'h3ff0, 14'h3fff, 14'h3fff, 16'h8000, 1'b1);
    drain();
    write_thresh(8'd255);
    add_box(0, 0, 10, 10, 16'h0001, 1'b0);
    add_box(0, 0, 10, 10, 16'h0002, 1'b0);
    add_box(1, 0, 10, 10, 16'h0003, 1'b1);
    drain();
    // store full: dropped beats, one carrying the last flag
    for (k = 0; k < NBox + 2; k++)
      add_box(14'($urandom_range(0, 200)), 14'($urandom_range(0, 200)),
              14'($urandom_range(1, 30)), 14'($urandom_range(1, 30)),
              16'($urandom), k == NBox + 1);
    for (k = 0; k < NBox + 1; k++)
      add_box(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
              16'($urandom), k == NBox);
    drain();
    for (p = 0; p < 8; p++) begin
      case (p)
        0: write_thresh(8'd0);
        1: write_thresh(8'd255);
        default: write_thresh(8'($urandom));
      endcase
      random_set($urandom_range(1, 8));
      drain();
    end
    if (errors == 0)
      $display("greedy_box_merge_max verification clean");
    else
      $display("greedy_box_merge_max verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("greedy_box_merge_max verification failed");
    $finish;
  end
endmodule

FILE: files.f
hdl/gbm_pkg.sv
hdl/gbm_ram.sv
hdl/gbm_datapath.sv
hdl/gbm_ctrl.sv
hdl/greedy_box_merge_max.sv
hdl/gbm_checker.sv
tb/greedy_box_merge_max_test.sv
